// ===== hdl/masked_byte_pattern_search_top_defines.svh =====
// ----------------------------------------------------------------------------
// masked byte pattern search assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MBPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define MBPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define MBPS_ASSERT(lbl, clk, rst_n, prop)
`define MBPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// shared types and constants of the masked byte pattern search
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MaxPatternBytes = 32;
  localparam int unsigned OffsetBits      = 32;
  localparam int unsigned LenBits         = 6;
  localparam int unsigned IdxBits         = $clog2(MaxPatternBytes);
  localparam int unsigned CfgIdxBits      = 3;
  localparam int unsigned CfgDataBits     = 64;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgPatternA     = 3'd0,
    CfgPatternB     = 3'd1,
    CfgPatternC     = 3'd2,
    CfgPatternD     = 3'd3,
    CfgWildcard     = 3'd4,
    CfgLength       = 3'd5,
    CfgReportEvery  = 3'd6
  } cfg_idx_e;

  // one window position as it moves down the chain
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } tap_t;

  // what a cell compares its incoming byte against
  typedef struct packed {
    logic       care;
    logic [7:0] expected;
  } probe_t;

endpackage

// ===== hdl/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// mbps_cell
// one window position: holds a byte, passes it on, compares the arriving byte
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            clear_i,
  input  mbps_pkg::tap_t   prev_i,
  input  mbps_pkg::probe_t probe_i,
  output mbps_pkg::tap_t   tap_o,
  output logic            eq_o
);

  logic       vld_q;
  logic [7:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= prev_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= prev_i.data;
    end
  end

  assign tap_o.vld  = vld_q;
  assign tap_o.data = data_q;

  // compare against the byte that lands here on this shift
  assign eq_o = !probe_i.care || (prev_i.data == probe_i.expected);

endmodule

// ===== hdl/masked_byte_pattern_search_top.sv =====
// output: a result is presented in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle unless stalled; cells shift and compare per accepted byte
// input stalls only while a held result is not taken by the consumer
// reset: window empty, offset counter and match flag cleared, pattern regs and wildcards
// zero, length one, first-match mode; no clearing pass is needed
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top
// wildcard byte pattern scanner over a streamed region, window as a cell chain
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_search_top_defines.svh"

module masked_byte_pattern_search_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mbps_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [mbps_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  // byte request
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                last_byte_i,
  // result request
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                match_found_o,
  output logic [31:0]                         match_offset_o,
  output logic                                region_done_o,
  output logic                                any_found_o
);

  localparam int unsigned NCells = mbps_pkg::MaxPatternBytes;

  // configuration registers
  logic [255:0]                 pattern_q;
  logic [31:0]                  wild_q;
  logic [mbps_pkg::LenBits-1:0] len_q;
  logic                         every_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      wild_q    <= '0;
      len_q     <= mbps_pkg::LenBits'(1);
      every_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mbps_pkg::cfg_idx_e'(cfg_idx_i))
        mbps_pkg::CfgPatternA:    pattern_q[63:0]    <= cfg_wdata_i;
        mbps_pkg::CfgPatternB:    pattern_q[127:64]  <= cfg_wdata_i;
        mbps_pkg::CfgPatternC:    pattern_q[191:128] <= cfg_wdata_i;
        mbps_pkg::CfgPatternD:    pattern_q[255:192] <= cfg_wdata_i;
        mbps_pkg::CfgWildcard:    wild_q  <= cfg_wdata_i[31:0];
        mbps_pkg::CfgLength:      len_q   <= cfg_wdata_i[mbps_pkg::LenBits-1:0];
        mbps_pkg::CfgReportEvery: every_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // length zero acts as one, oversize clamps to the window depth
  logic [mbps_pkg::LenBits-1:0] len_eff;
  always_comb begin
    priority if (len_q == '0) begin
      len_eff = mbps_pkg::LenBits'(1);
    end else if (len_q > mbps_pkg::LenBits'(NCells)) begin
      len_eff = mbps_pkg::LenBits'(NCells);
    end else begin
      len_eff = len_q;
    end
  end

  // handshake
  logic out_valid_q;
  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // cell chain
  mbps_pkg::tap_t   cell_in  [NCells];
  mbps_pkg::tap_t   cell_tap [NCells];
  mbps_pkg::probe_t probe    [NCells];
  logic [NCells-1:0] eq;
  logic             clear;

  assign clear = accept && last_byte_i;

  for (genvar k = 0; k < NCells; k++) begin : g_cell
    logic [mbps_pkg::IdxBits-1:0] pidx;

    if (k == 0) begin : g_head
      assign cell_in[k] = '{vld: 1'b1, data: data_byte_i};
    end else begin : g_link
      assign cell_in[k] = cell_tap[k-1];
    end

    // cell k holds the byte that pairs with pattern byte len-1-k
    assign pidx = mbps_pkg::IdxBits'(len_eff - mbps_pkg::LenBits'(k) - mbps_pkg::LenBits'(1));

    always_comb begin
      if (mbps_pkg::LenBits'(k) < len_eff) begin
        probe[k].care     = !wild_q[pidx];
        probe[k].expected = pattern_q[{pidx, 3'b000} +: 8];
      end else begin
        probe[k].care     = 1'b0;
        probe[k].expected = 8'h00;
      end
    end

    mbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .clear_i (clear),
      .prev_i  (cell_in[k]),
      .probe_i (probe[k]),
      .tap_o   (cell_tap[k]),
      .eq_o    (eq[k])
    );
  end

  // match needs a real byte in the oldest compared position
  logic [mbps_pkg::IdxBits-1:0] tail_idx;
  logic                         tail_vld;
  logic                         hit;

  assign tail_idx = mbps_pkg::IdxBits'(len_eff - mbps_pkg::LenBits'(1));
  assign tail_vld = cell_in[tail_idx].vld;
  assign hit      = tail_vld && (&eq);

  // region tracking
  logic [mbps_pkg::OffsetBits-1:0] seen_cnt_q, seen_cnt_d;
  logic                            seen_q, seen_d;
  logic [mbps_pkg::OffsetBits-1:0] start_offs;
  logic                            report;
  logic                            emit;

  assign seen_cnt_d = seen_cnt_q + mbps_pkg::OffsetBits'(1);
  assign seen_d     = seen_q || hit;
  assign start_offs = seen_cnt_d - mbps_pkg::OffsetBits'(len_eff);
  assign report     = hit && (every_q || !seen_q);
  assign emit       = report || last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_cnt_q <= '0;
      seen_q     <= 1'b0;
    end else if (accept) begin
      seen_cnt_q <= last_byte_i ? '0 : seen_cnt_d;
      seen_q     <= last_byte_i ? 1'b0 : seen_d;
    end
  end

  // output register
  logic        out_valid_d;
  logic        match_found_q;
  logic [31:0] match_offset_q;
  logic        region_done_q;
  logic        any_found_q;

  always_comb begin
    priority if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      match_found_q  <= report;
      match_offset_q <= report ? 32'(start_offs) : 32'd0;
      region_done_q  <= last_byte_i;
      any_found_q    <= last_byte_i && seen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = match_found_q;
  assign match_offset_o = match_offset_q;
  assign region_done_o  = region_done_q;
  assign any_found_o    = any_found_q;

  // checks
  `MBPS_ASSERT(a_no_empty_result, clk_i, rst_ni,
    out_valid_o |-> (match_found_o || region_done_o))
  `MBPS_ASSERT(a_any_only_at_end, clk_i, rst_ni,
    (out_valid_o && !region_done_o) |-> !any_found_o)
  `MBPS_ASSERT(a_ready_when_empty, clk_i, rst_ni,
    !out_valid_o |-> in_ready_o)
  `MBPS_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |-> !out_valid_o)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked byte pattern search testbench
// streams regions of bytes through the scanner under changing patterns,
// wildcard masks, lengths and report modes, predicts every match and region
// done result and compares them with what the block hands out
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic        region_done;
    logic        any_found;
  } scan_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [mbps_pkg::CfgIdxBits-1:0]  cfg_idx_i;
  logic [mbps_pkg::CfgDataBits-1:0] cfg_wdata_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [7:0]                       data_byte_i;
  logic                             last_byte_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic                             match_found_o;
  logic [31:0]                      match_offset_o;
  logic                             region_done_o;
  logic                             any_found_o;

  masked_byte_pattern_search_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_found_o  (match_found_o),
    .match_offset_o (match_offset_o),
    .region_done_o  (region_done_o),
    .any_found_o    (any_found_o)
  );

  // scanner image: configuration
  logic [63:0] pat_regs [4];
  logic [31:0] wild_mask;
  logic [5:0]  len_reg;
  logic        every_mode;
  // scanner image: region state
  logic [7:0]  win [mbps_pkg::MaxPatternBytes];
  logic [31:0] seen_count;
  logic        hit_flag;
  int unsigned fill;

  scan_result_t pending_results [$];
  int unsigned  fail_count;
  int unsigned  sent_count;
  int unsigned  gap_pct;
  int unsigned  stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [7:0] pattern_byte(input int unsigned i);
    return pat_regs[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > mbps_pkg::MaxPatternBytes) return mbps_pkg::MaxPatternBytes;
    return len_reg;
  endfunction

  function automatic void clear_region();
    for (int k = 0; k < mbps_pkg::MaxPatternBytes; k++) win[k] = 8'h00;
    seen_count = '0;
    hit_flag   = 1'b0;
    fill       = 0;
  endfunction

  // returns 1 when the byte produces a result
  function automatic bit scan_predict(input logic [7:0] b, input logic lst,
                                      output scan_result_t res);
    int unsigned n;
    bit          hit;
    bit          report;
    n      = eff_len();
    report = 1'b0;
    res    = '0;
    for (int k = mbps_pkg::MaxPatternBytes - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    if (fill < mbps_pkg::MaxPatternBytes) fill++;
    seen_count = seen_count + 1;
    hit = (fill >= n);
    for (int unsigned i = 0; i < n; i++) begin
      if (!wild_mask[i] && win[n - 1 - i] != pattern_byte(i)) hit = 1'b0;
    end
    if (hit) begin
      report   = every_mode || !hit_flag;
      hit_flag = 1'b1;
      if (report) begin
        res.match_found  = 1'b1;
        res.match_offset = seen_count - 32'(n);
      end
    end
    if (lst) begin
      res.region_done = 1'b1;
      res.any_found   = hit_flag;
      clear_region();
    end
    return report || lst;
  endfunction

  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: match %0b offset %0h done %0b any %0b",
               match_found_o, match_offset_o, region_done_o, any_found_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (match_found_o !== want.match_found) begin
          $error("match_found: expected %0b, got %0b", want.match_found, match_found_o);
          fail_count++;
        end
        if (match_offset_o !== want.match_offset) begin
          $error("match_offset: expected %0h, got %0h", want.match_offset, match_offset_o);
          fail_count++;
        end
        if (region_done_o !== want.region_done) begin
          $error("region_done: expected %0b, got %0b", want.region_done, region_done_o);
          fail_count++;
        end
        if (any_found_o !== want.any_found) begin
          $error("any_found: expected %0b, got %0b", want.any_found, any_found_o);
          fail_count++;
        end
      end
    end
  end

  // one byte request, held until in_ready_o is seen high, with random idle gaps before it
  task automatic push_byte(input logic [7:0] b, input logic lst);
    scan_result_t res;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if (scan_predict(b, lst, res)) pending_results = {pending_results, res};
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input mbps_pkg::cfg_idx_e idx, input logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    unique case (idx)
      mbps_pkg::CfgPatternA:    pat_regs[0] = v;
      mbps_pkg::CfgPatternB:    pat_regs[1] = v;
      mbps_pkg::CfgPatternC:    pat_regs[2] = v;
      mbps_pkg::CfgPatternD:    pat_regs[3] = v;
      mbps_pkg::CfgWildcard:    wild_mask   = v[31:0];
      mbps_pkg::CfgLength:      len_reg     = v[5:0];
      mbps_pkg::CfgReportEvery: every_mode  = v[0];
      default: ;
    endcase
  endtask

  // unused upper bits carry noise, the block must ignore them
  task automatic load_config(input logic [255:0] pat, input logic [31:0] wild,
                             input logic [5:0] len, input logic every);
    write_reg(mbps_pkg::CfgPatternA, pat[63:0]);
    write_reg(mbps_pkg::CfgPatternB, pat[127:64]);
    write_reg(mbps_pkg::CfgPatternC, pat[191:128]);
    write_reg(mbps_pkg::CfgPatternD, pat[255:192]);
    write_reg(mbps_pkg::CfgWildcard, {$urandom, wild});
    write_reg(mbps_pkg::CfgLength, {$urandom, 26'($urandom), len});
    write_reg(mbps_pkg::CfgReportEvery, {$urandom, 31'($urandom), every});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 99) < 30) return pattern_byte($urandom_range(0, eff_len() - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly planted pattern copies, some damaged, with noise between them
  task automatic send_random_region();
    logic [7:0]  bytes_q [$];
    int unsigned chunks;
    int unsigned base;
    int unsigned n;
    chunks = $urandom_range(0, 4);
    for (int unsigned k = 0; k < chunks; k++) begin
      if ($urandom_range(0, 99) < 65) begin
        base = bytes_q.size();
        for (int unsigned j = 0; j < eff_len(); j++) begin
          bytes_q = {bytes_q, wild_mask[j] ? 8'($urandom_range(0, 255)) : pattern_byte(j)};
        end
        if ($urandom_range(0, 99) < 15) begin
          n = base + $urandom_range(0, eff_len() - 1);
          bytes_q[n] = bytes_q[n] ^ (8'h01 << $urandom_range(0, 7));
        end
      end else begin
        repeat ($urandom_range(1, 4)) bytes_q = {bytes_q, noise_byte()};
      end
    end
    if (bytes_q.size() == 0) bytes_q = {bytes_q, noise_byte()};
    foreach (bytes_q[j]) push_byte(bytes_q[j], j == bytes_q.size() - 1);
  endtask

  task automatic random_config();
    logic [255:0] pat;
    logic [31:0]  wild;
    logic [5:0]   len;
    pat = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       wild = '0;
      1:       wild = '1;
      default: wild = $urandom & $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       len = 6'd0;
      1:       len = 6'd1;
      2:       len = 6'd32;
      3:       len = 6'($urandom_range(33, 63));
      4:       len = 6'($urandom_range(9, 31));
      default: len = 6'($urandom_range(2, 8));
    endcase
    load_config(pat, wild, len, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_state();
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // AA AA over AA AA AA overlaps, the second match ends on the last byte
  task automatic test_overlap();
    load_config({240'h0, 16'hAAAA}, 32'h0, 6'd2, 1'b1);
    repeat (2) push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b1);
    wait_idle();
    load_config({240'h0, 16'hAAAA}, 32'h0, 6'd2, 1'b0);
    repeat (2) push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b1);
    wait_idle();
  endtask

  task automatic test_wildcards();
    load_config({224'h0, 32'h12345678}, 32'hFFFF_FFFF, 6'd4, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b1);
    wait_idle();
  endtask

  task automatic test_length_limits();
    load_config({248'h0, 8'h7F}, 32'h0, 6'd0, 1'b0);
    push_byte(8'h7F, 1'b1);
    wait_idle();
    load_config('1, 32'h0, 6'd63, 1'b1);
    repeat (2) push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_short_region();
    load_config({232'h0, 24'h332211}, 32'h0, 6'd3, 1'b1);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (2) begin
      random_config();
      sent_count = 0;
      while (sent_count < 50) send_random_region();
      wait_idle();
    end
  endtask

  initial begin
    fail_count = 0;
    sent_count = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    for (int k = 0; k < 4; k++) pat_regs[k] = '0;
    wild_mask  = '0;
    len_reg    = 6'd1;
    every_mode = 1'b0;
    clear_region();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_overlap();
    test_wildcards();
    test_length_limits();
    test_short_region();
    test_random_traffic(0, 0);
    test_random_traffic(82, 0);
    test_random_traffic(0, 82);
    test_random_traffic(22, 22);

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
